### sv/circular_deque_core_macros.svh
// Assertion macros shared by the deque checker.
`ifndef CIRCULAR_DEQUE_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_CORE_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define CDQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define CDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/cdq_pkg.sv
// Package: shared types and constants of the circular deque.
`default_nettype none

package cdq_pkg;

    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic exec;     // update pointers, access the ring store
        logic load;     // fill the result register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_stall;  // result register holds an item not yet taken
    } t_dp_sts;

endpackage

`default_nettype wire

### sv/cdq_if.sv
// Interfaces: operation channel and result channel of the deque.
`default_nettype none

interface cdq_op_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::OP_W-1:0]            operation;
    logic signed [cdq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [cdq_pkg::DATA_W-1:0]   data_out;
    logic                                error;
    logic                                is_empty;
    logic                                is_full;
    logic [cdq_pkg::COUNT_W-1:0]         item_count;

    modport source (output valid, output data_out, output error, output is_empty,
                    output is_full, output item_count, input ready);
    modport sink   (input valid, input data_out, input error, input is_empty,
                    input is_full, input item_count, output ready);
endinterface

`default_nettype wire

### sv/cdq_ctrl.sv
// Controller: sequences capture, store access and result load per item.
`default_nettype none

module cdq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  cdq_pkg::t_dp_sts  i_sts,
    output cdq_pkg::t_dp_cmd  o_cmd
);

    cdq_pkg::t_state r_state;
    cdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = cdq_pkg::ST_EXEC;
                end
            end
            cdq_pkg::ST_EXEC: begin
                n_state = cdq_pkg::ST_LOAD;
            end
            cdq_pkg::ST_LOAD: begin
                if (!i_sts.out_stall) begin
                    n_state = cdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            cdq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            cdq_pkg::ST_LOAD: begin
                o_cmd.load = !i_sts.out_stall;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/cdq_datapath.sv
// Datapath: ring store, head/tail pointers, occupancy and result register.
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  cdq_pkg::t_dp_cmd                      i_cmd,
    output cdq_pkg::t_dp_sts                      o_sts,
    input  wire [cdq_pkg::OP_W-1:0]               i_operation,
    input  wire signed [cdq_pkg::DATA_W-1:0]      i_value,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [cdq_pkg::DATA_W-1:0]     o_data_out,
    output logic                                  o_error,
    output logic                                  o_is_empty,
    output logic                                  o_is_full,
    output logic [cdq_pkg::COUNT_W-1:0]           o_item_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic signed [cdq_pkg::DATA_W-1:0] r_mem [DEPTH];

    logic [cdq_pkg::OP_W-1:0]          r_op;
    logic signed [cdq_pkg::DATA_W-1:0] r_value;
    logic [PTR_W-1:0]                  r_head;
    logic [PTR_W-1:0]                  r_tail;
    logic [CNT_W-1:0]                  r_count;
    logic                              r_err;
    logic                              r_ret;
    logic signed [cdq_pkg::DATA_W-1:0] r_rd_data;
    logic                              r_out_valid;

    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] n_tail;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] tail_dec;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             err;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);

    // Decode the held operation against the current occupancy.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_addr = tail_inc;
        rd_en   = 1'b0;
        rd_addr = r_head;
        err     = 1'b0;
        unique case (cdq_pkg::t_op'(r_op))
            cdq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                    err = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = tail_inc;
                    n_tail  = tail_inc;
                    n_count = r_count + 1'b1;
                end
            end
            cdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    err = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    err = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            cdq_pkg::OP_POP_REAR: begin
                if (empty) begin
                    err = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_tail;
                    n_tail  = tail_dec;
                    n_count = r_count - 1'b1;
                end
            end
            cdq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    err = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                end
            end
            cdq_pkg::OP_PEEK_REAR: begin
                if (empty) begin
                    err = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_tail;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_err <= err;
            r_ret <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= LAST_IDX;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Ring store: one write or one registered read per item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_data_out   <= r_ret ? r_rd_data : '0;
            o_error      <= r_err;
            o_is_empty   <= empty;
            o_is_full    <= full;
            o_item_count <= cdq_pkg::COUNT_W'(r_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.out_stall = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

### sv/circular_deque_core.sv
// Top level: double-ended queue on a ring store, controller plus datapath.
//
//  Channel  Dir  Handshake          Payload
//  i_op     in   valid / ready      operation[2:0], value[31:0] signed
//  o_res    out  valid / ready      data_out[31:0] signed, error, is_empty,
//                                   is_full, item_count[4:0]
//
// Each item passes through these steps: capture it, access the ring store (write for a
// push, registered read for a pop or peek, pointer and count update), load the
// result register. Reset clears the pointers, the count, the controller and the
// result valid; store contents stay undefined until written.
// A result not yet taken holds the next item before its load, with input ready low.
`default_nettype none

module circular_deque_core #(
    parameter int DEPTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cdq_op_if.sink     i_op,
    cdq_res_if.source  o_res
);

    cdq_pkg::t_dp_cmd dp_cmd;
    cdq_pkg::t_dp_sts dp_sts;
    logic             in_ready;

    // Sequence each item through its three steps.
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_op.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    assign i_op.ready = in_ready;

    // Hold the store, pointers, count and the result register.
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_operation  (i_op.operation),
        .i_value      (i_op.value),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_data_out   (o_res.data_out),
        .o_error      (o_res.error),
        .o_is_empty   (o_res.is_empty),
        .o_is_full    (o_res.is_full),
        .o_item_count (o_res.item_count)
    );

endmodule

`default_nettype wire

### sv/cdq_checker.sv
// Checker: port-level properties of the deque results, bound to the top level.
`default_nettype none
`include "circular_deque_core_macros.svh"

module cdq_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_res_valid,
    input wire signed [cdq_pkg::DATA_W-1:0]   i_data_out,
    input wire                                i_error,
    input wire                                i_is_empty,
    input wire                                i_is_full,
    input wire [cdq_pkg::COUNT_W-1:0]         i_item_count
);

    `CDQ_ASSERT_ALWAYS(a_no_result_after_reset, i_clk,
        !i_rst_n |=> !i_res_valid, "result after reset")
    `CDQ_ASSERT(a_empty_full_excl, i_clk, i_rst_n,
        i_res_valid |-> !(i_is_empty && i_is_full), "empty and full together")
    `CDQ_ASSERT(a_empty_count, i_clk, i_rst_n,
        i_res_valid |-> (i_is_empty == (i_item_count == '0)),
        "empty flag disagrees with count")
    `CDQ_ASSERT(a_error_zero_data, i_clk, i_rst_n,
        (i_res_valid && i_error) |-> (i_data_out == '0), "rejected item returns data")

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_data_out   (o_res.data_out),
    .i_error      (o_res.error),
    .i_is_empty   (o_res.is_empty),
    .i_is_full    (o_res.is_full),
    .i_item_count (o_res.item_count)
);

`default_nettype wire
